>>> hw/rtl/mtp_pkg.sv
`timescale 1ns / 1ps
package mtp_pkg;

    localparam int unsigned C_HEAD_LEN      = 12;
    localparam int unsigned C_POS_W         = 9;
    localparam int unsigned C_LEN_W         = 10;
    localparam int unsigned C_INDEX_W       = 7;
    localparam int unsigned C_MAX_REGISTERS = 125;

    localparam logic [C_POS_W-1:0] C_POS_MAX    = 9'd511;
    localparam logic [C_POS_W-1:0] C_DATA_START = 9'd9;

    localparam logic [C_LEN_W-1:0] C_RESP_MIN_LEN  = 10'd8;
    localparam logic [C_LEN_W-1:0] C_READ_MIN_LEN  = 10'd9;
    localparam logic [C_LEN_W-1:0] C_FULL_MIN_LEN  = 10'd12;
    localparam logic [C_LEN_W-1:0] C_DATA_START_LEN = 10'd9;

    localparam logic [7:0] C_FC_READ_HOLDING = 8'h03;
    localparam logic [7:0] C_FC_WRITE_SINGLE = 8'h06;

    localparam logic [C_INDEX_W-1:0] C_MAX_REG_COUNT = C_INDEX_W'(C_MAX_REGISTERS);

    localparam logic C_ROLE_RESPONSE = 1'b0;
    localparam logic C_ROLE_REQUEST  = 1'b1;

    localparam logic C_KIND_WORD    = 1'b0;
    localparam logic C_KIND_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SHORT     = 2'd1,
        ST_BAD_COUNT = 2'd2,
        ST_BAD_FUNC  = 2'd3
    } t_status;

    typedef struct packed {
        logic                 kind;
        logic                 run_last;
        logic [1:0]           status;
        logic [15:0]          transaction_id;
        logic [15:0]          protocol_id;
        logic [15:0]          length_field;
        logic [7:0]           unit_id;
        logic [7:0]           function_code;
        logic [15:0]          address;
        logic [15:0]          data_word;
        logic [C_INDEX_W-1:0] word_index;
    } t_result;

endpackage

>>> hw/rtl/mtp_in_if.sv
`timescale 1ns / 1ps
interface mtp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;

    modport source (output valid, output frame_byte, output frame_end, input ready);
    modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

>>> hw/rtl/mtp_out_if.sv
`timescale 1ns / 1ps
interface mtp_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic        run_last;
    logic [1:0]  status;
    logic [15:0] transaction_id;
    logic [15:0] protocol_id;
    logic [15:0] length_field;
    logic [7:0]  unit_id;
    logic [7:0]  function_code;
    logic [15:0] address;
    logic [15:0] data_word;
    logic [6:0]  word_index;

    modport source (
        output valid, output kind, output run_last, output status,
        output transaction_id, output protocol_id, output length_field,
        output unit_id, output function_code, output address,
        output data_word, output word_index, input ready
    );
    modport sink (
        input valid, input kind, input run_last, input status,
        input transaction_id, input protocol_id, input length_field,
        input unit_id, input function_code, input address,
        input data_word, input word_index, output ready
    );
endinterface

>>> hw/rtl/modbus_tcp_frame_parser.sv
`timescale 1ns / 1ps
// modbus tcp frame parser
// i_in: frame bytes, one item per byte, frame_end high on the last byte of a frame
// o_out: result items; kind 0 is a register word, kind 1 the frame summary
// i_cfg_we / i_cfg_wdata: role register, 0 parses responses, 1 parses requests;
//   write it only while no frame is in progress
// each accepted byte is parsed in the cycle it is taken and gives zero, one or two
// results; they enter a four-entry result queue and, if it was empty, the first
// appears on o_out the cycle after the byte was accepted
// throughput is one byte per cycle while i_in.ready is high; a final byte that also
// completes a register word yields two results, which leave the queue one by one
// i_in.ready is high while the queue has room for two results, so a stalled
// receiver holds results in the queue and stops input once three are waiting
// reset clears the byte position, the role and the stored header fields (unit id
// resets to one) and empties the queue; the header byte store needs no reset
module modbus_tcp_frame_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_wdata,
    mtp_in_if.sink                i_in,
    mtp_out_if.source             o_out
);
    import mtp_pkg::*;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = 2;

    logic                 r_role;
    logic [C_POS_W-1:0]   r_pos, n_pos;
    logic [7:0]           r_head [C_HEAD_LEN];
    logic [7:0]           n_head [C_HEAD_LEN];
    logic [7:0]           r_held, n_held;
    logic [15:0]          r_first, n_first;
    logic [15:0]          r_trans, n_trans;
    logic [15:0]          r_proto, n_proto;
    logic [15:0]          r_length, n_length;
    logic [7:0]           r_unit, n_unit;
    logic [7:0]           r_func, n_func;
    logic [15:0]          r_addr, n_addr;
    logic [15:0]          r_quant, n_quant;
    logic [15:0]          r_value, n_value;
    logic [C_INDEX_W-1:0] r_count, n_count;

    t_result              r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [FIFO_AW:0]     r_fill;

    logic                 accept;
    logic                 pop;
    logic [C_POS_W-1:0]   q_off;
    logic [7:0]           word_idx;
    logic [C_INDEX_W-1:0] rc;
    logic                 stream_ok;
    logic                 word_valid;
    logic                 sum_valid;
    logic [15:0]          word_val;
    logic [C_LEN_W-1:0]   len;
    logic [C_LEN_W-1:0]   data_end;
    t_status              status;
    t_result              word_res;
    t_result              sum_res;
    logic [1:0]           push_cnt;

    assign accept = i_in.valid & i_in.ready;
    assign pop    = o_out.valid & o_out.ready;

    always_comb begin
        for (int k = 0; k < C_HEAD_LEN; k++) begin
            n_head[k] = r_head[k];
        end
        if (r_pos < C_POS_W'(C_HEAD_LEN)) begin
            n_head[r_pos[3:0]] = i_in.frame_byte;
        end

        n_pos    = r_pos;
        n_held   = r_held;
        n_first  = r_first;
        n_trans  = r_trans;
        n_proto  = r_proto;
        n_length = r_length;
        n_unit   = r_unit;
        n_func   = r_func;
        n_addr   = r_addr;
        n_quant  = r_quant;
        n_value  = r_value;
        n_count  = r_count;
        status   = ST_OK;

        // register word streaming
        q_off     = r_pos - C_DATA_START;
        word_idx  = q_off[C_POS_W-1:1];
        rc        = n_head[8][7:1];
        word_val  = {r_held, i_in.frame_byte};
        stream_ok = (r_role == C_ROLE_RESPONSE) && (r_pos >= C_DATA_START)
                    && (n_head[7] == C_FC_READ_HOLDING) && (rc <= C_MAX_REG_COUNT)
                    && (word_idx < {1'b0, rc});
        word_valid = accept & stream_ok & q_off[0];
        if (accept && stream_ok && !q_off[0]) begin
            n_held = i_in.frame_byte;
        end
        if (word_valid && word_idx == 8'd0) begin
            n_first = word_val;
        end

        // end of frame checks and commit
        len       = {1'b0, r_pos} + C_LEN_W'(1);
        data_end  = C_DATA_START_LEN + {2'b00, n_head[8]};
        sum_valid = accept & i_in.frame_end;
        if (i_in.frame_end) begin
            if (r_role == C_ROLE_RESPONSE) begin
                if (len < C_RESP_MIN_LEN) begin
                    status = ST_SHORT;
                end else begin
                    n_trans  = {n_head[0], n_head[1]};
                    n_proto  = {n_head[2], n_head[3]};
                    n_length = {n_head[4], n_head[5]};
                    n_unit   = n_head[6];
                    n_func   = n_head[7];
                    if (n_head[7] == C_FC_READ_HOLDING) begin
                        if (len < C_READ_MIN_LEN) begin
                            status = ST_SHORT;
                        end else begin
                            n_count = rc;
                            if (rc > C_MAX_REG_COUNT) begin
                                status = ST_BAD_COUNT;
                            end else if (len < data_end) begin
                                status = ST_SHORT;
                            end else if (rc != '0) begin
                                n_value = n_first;
                            end
                        end
                    end else if (n_head[7] == C_FC_WRITE_SINGLE) begin
                        if (len < C_FULL_MIN_LEN) begin
                            status = ST_SHORT;
                        end else begin
                            n_addr  = {n_head[8], n_head[9]};
                            n_value = {n_head[10], n_head[11]};
                        end
                    end else begin
                        status = ST_BAD_FUNC;
                    end
                end
            end else begin
                if (len < C_FULL_MIN_LEN) begin
                    status = ST_SHORT;
                end else begin
                    n_trans  = {n_head[0], n_head[1]};
                    n_proto  = {n_head[2], n_head[3]};
                    n_length = {n_head[4], n_head[5]};
                    n_unit   = n_head[6];
                    n_func   = n_head[7];
                    n_addr   = {n_head[8], n_head[9]};
                    if (n_head[7] == C_FC_READ_HOLDING) begin
                        n_quant = {n_head[10], n_head[11]};
                    end else if (n_head[7] == C_FC_WRITE_SINGLE) begin
                        n_value = {n_head[10], n_head[11]};
                    end else begin
                        status = ST_BAD_FUNC;
                    end
                end
            end
        end

        if (i_in.frame_end) begin
            n_pos = '0;
        end else if (r_pos < C_POS_MAX) begin
            n_pos = r_pos + C_POS_W'(1);
        end

        word_res                = '0;
        word_res.kind           = C_KIND_WORD;
        word_res.run_last       = ~i_in.frame_end;
        word_res.data_word      = word_val;
        word_res.word_index     = word_idx[C_INDEX_W-1:0];

        sum_res.kind            = C_KIND_SUMMARY;
        sum_res.run_last        = 1'b1;
        sum_res.status          = status;
        sum_res.transaction_id  = n_trans;
        sum_res.protocol_id     = n_proto;
        sum_res.length_field    = n_length;
        sum_res.unit_id         = n_unit;
        sum_res.function_code   = n_func;
        sum_res.address         = n_addr;
        sum_res.data_word       = (r_role == C_ROLE_REQUEST && n_func == C_FC_READ_HOLDING)
                                  ? n_quant : n_value;
        sum_res.word_index      = n_count;

        push_cnt = {1'b0, word_valid} + {1'b0, sum_valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_role   <= C_ROLE_RESPONSE;
            r_pos    <= '0;
            r_trans  <= '0;
            r_proto  <= '0;
            r_length <= '0;
            r_unit   <= 8'd1;
            r_func   <= '0;
            r_addr   <= '0;
            r_quant  <= '0;
            r_value  <= '0;
            r_count  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_role <= i_cfg_wdata;
            end
            if (accept) begin
                r_pos    <= n_pos;
                r_trans  <= n_trans;
                r_proto  <= n_proto;
                r_length <= n_length;
                r_unit   <= n_unit;
                r_func   <= n_func;
                r_addr   <= n_addr;
                r_quant  <= n_quant;
                r_value  <= n_value;
                r_count  <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int k = 0; k < C_HEAD_LEN; k++) begin
                r_head[k] <= n_head[k];
            end
            r_held  <= n_held;
            r_first <= n_first;
        end
        if (word_valid) begin
            r_fifo[r_wr_ptr] <= word_res;
        end
        if (sum_valid) begin
            r_fifo[r_wr_ptr + FIFO_AW'(word_valid)] <= sum_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_AW'(push_cnt);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_fill <= r_fill + (FIFO_AW+1)'(push_cnt) - (FIFO_AW+1)'(pop);
        end
    end

    assign i_in.ready = (r_fill <= (FIFO_AW+1)'(FIFO_DEPTH - 2));

    assign o_out.valid          = (r_fill != '0);
    assign o_out.kind           = r_fifo[r_rd_ptr].kind;
    assign o_out.run_last       = r_fifo[r_rd_ptr].run_last;
    assign o_out.status         = r_fifo[r_rd_ptr].status;
    assign o_out.transaction_id = r_fifo[r_rd_ptr].transaction_id;
    assign o_out.protocol_id    = r_fifo[r_rd_ptr].protocol_id;
    assign o_out.length_field   = r_fifo[r_rd_ptr].length_field;
    assign o_out.unit_id        = r_fifo[r_rd_ptr].unit_id;
    assign o_out.function_code  = r_fifo[r_rd_ptr].function_code;
    assign o_out.address        = r_fifo[r_rd_ptr].address;
    assign o_out.data_word      = r_fifo[r_rd_ptr].data_word;
    assign o_out.word_index     = r_fifo[r_rd_ptr].word_index;

endmodule
